>>> rtl/stereo_frame_fifo_with_peak_meter_defines.svh
// ----------------------------------------------------------------------------
// Stereo frame FIFO assertion macros
// Concurrent check macros shared by the RTL files. They expand to nothing
// when SYNTHESIS is defined. Each use expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef STEREO_FRAME_FIFO_WITH_PEAK_METER_DEFINES_SVH
`define STEREO_FRAME_FIFO_WITH_PEAK_METER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication check.
`define SFFPM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication check.
`define SFFPM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SFFPM_ASSERT_IMPL(lbl, ante, cons, msg)
`define SFFPM_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> rtl/sffpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo frame FIFO package
// Item types, field widths, opcodes and the sample magnitude function.
// ----------------------------------------------------------------------------
package sffpm_pkg;

    localparam int SAMPLE_W = 24;
    localparam int PEAK_W   = 23;
    localparam int COUNT_W  = 7;
    localparam int TOTAL_W  = 32;
    localparam int FRAME_W  = 2 * SAMPLE_W;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic                       opcode;
        logic signed [SAMPLE_W-1:0] in_left;
        logic signed [SAMPLE_W-1:0] in_right;
        logic [COUNT_W-1:0]         block_frames;
        logic                       flush_first;
    } req_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_left;
        logic signed [SAMPLE_W-1:0] out_right;
        logic                       filled;
        logic                       last;
        logic [PEAK_W-1:0]          peak_left;
        logic [PEAK_W-1:0]          peak_right;
        logic [COUNT_W-1:0]         delivered;
        logic [TOTAL_W-1:0]         underrun_total;
    } rsp_item_t;

    // Control from the sequencer to the output stage.
    typedef struct packed {
        logic block_start;
        logic iss_valid;
        logic iss_filled;
        logic iss_last;
    } seq_ctrl_t;

    // Absolute value of a Q1.23 sample; the most negative code saturates.
    function automatic logic [PEAK_W-1:0] magnitude(input logic [SAMPLE_W-1:0] s);
        logic [SAMPLE_W-1:0] neg;
        neg = ~s + 1'b1;
        if (!s[SAMPLE_W-1])
        begin
            magnitude = s[PEAK_W-1:0];
        end
        else if (neg[SAMPLE_W-1])
        begin
            magnitude = '1;
        end
        else
        begin
            magnitude = neg[PEAK_W-1:0];
        end
    endfunction

endpackage

>>> rtl/sffpm_frame_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame store
// Simple dual-port synchronous RAM holding one left/right frame per entry,
// with one write port and one registered read port.
// ----------------------------------------------------------------------------
module sffpm_frame_ram
    import sffpm_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
)
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  logic [FRAME_W-1:0] wr_data,
    input  logic               rd_en,
    input  logic [AW-1:0]      rd_addr,
    output logic [FRAME_W-1:0] rd_data
);

    logic [FRAME_W-1:0] mem [DEPTH];
    logic [FRAME_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/sffpm_seq.sv
`timescale 1ns / 1ps
`include "stereo_frame_fifo_with_peak_meter_defines.svh"
// ----------------------------------------------------------------------------
// Stereo frame FIFO sequencer
// Owns the queue pointers, the underrun counter and the configuration bit.
// Stores pushed frames and reads the store once per filled frame of a block.
// ----------------------------------------------------------------------------
module sffpm_seq
    import sffpm_pkg::*;
#(
    parameter int CAPACITY  = 1024,
    parameter int MAX_BLOCK = 64,
    parameter int AW        = 10
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  req_item_t          req_item,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    input  logic               issue_ok,
    output seq_ctrl_t          ctrl,
    output logic [TOTAL_W-1:0] underrun_total,
    output logic               wr_en,
    output logic [AW-1:0]      wr_addr,
    output logic [FRAME_W-1:0] wr_data,
    output logic               rd_en,
    output logic [AW-1:0]      rd_addr
);

    localparam int LW = AW + 1;
    localparam int CW = (LW > COUNT_W) ? LW : COUNT_W;

    typedef enum logic {S_IDLE, S_RUN} state_t;

    state_t             state_reg, state_next;
    logic               w_wrap_reg, w_wrap_next;
    logic               r_wrap_reg, r_wrap_next;
    logic [AW-1:0]      w_slot_reg, w_slot_next;
    logic [AW-1:0]      r_slot_reg, r_slot_next;
    logic [COUNT_W-1:0] req_len_reg, req_len_next;
    logic [COUNT_W-1:0] avail_reg, avail_next;
    logic [COUNT_W-1:0] issued_reg, issued_next;
    logic [TOTAL_W-1:0] underrun_reg, underrun_next;
    logic               starve_reg, starve_next;

    logic [LW-1:0]      level;
    logic               full;
    logic               accept;
    logic [COUNT_W-1:0] req_len;
    logic [COUNT_W-1:0] avail_now;
    logic               iss_fire;
    logic               iss_filled;
    logic               iss_last;

    // The fill level is the pointer distance; equal wrap bits mean no wrap.
    always_comb
    begin
        if (w_wrap_reg == r_wrap_reg)
        begin
            level = LW'(w_slot_reg) - LW'(r_slot_reg);
        end
        else
        begin
            level = LW'(CAPACITY) - LW'(r_slot_reg) + LW'(w_slot_reg);
        end
    end

    assign full      = (level == LW'(CAPACITY));
    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;

    // Clamp the requested length to 1..MAX_BLOCK.
    always_comb
    begin
        if (req_item.block_frames == '0)
        begin
            req_len = COUNT_W'(1);
        end
        else if (req_item.block_frames > COUNT_W'(MAX_BLOCK))
        begin
            req_len = COUNT_W'(MAX_BLOCK);
        end
        else
        begin
            req_len = req_item.block_frames;
        end
    end

    always_comb
    begin
        if (req_item.flush_first)
        begin
            avail_now = '0;
        end
        else if (CW'(level) < CW'(req_len))
        begin
            avail_now = COUNT_W'(level);
        end
        else
        begin
            avail_now = req_len;
        end
    end

    assign iss_fire   = (state_reg == S_RUN) && issue_ok;
    assign iss_filled = (issued_reg < avail_reg);
    assign iss_last   = (COUNT_W'(issued_reg + 1'b1) == req_len_reg);

    always_comb
    begin
        state_next    = state_reg;
        w_wrap_next   = w_wrap_reg;
        r_wrap_next   = r_wrap_reg;
        w_slot_next   = w_slot_reg;
        r_slot_next   = r_slot_reg;
        req_len_next  = req_len_reg;
        avail_next    = avail_reg;
        issued_next   = issued_reg;
        underrun_next = underrun_reg;
        starve_next   = cfg_we ? cfg_wdata : starve_reg;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        ctrl          = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (req_item.opcode == OP_PUSH))
                begin
                    if (!full)
                    begin
                        wr_en = 1'b1;
                        if (w_slot_reg == AW'(CAPACITY - 1))
                        begin
                            w_slot_next = '0;
                            w_wrap_next = ~w_wrap_reg;
                        end
                        else
                        begin
                            w_slot_next = w_slot_reg + 1'b1;
                        end
                    end
                end
                else if (accept)
                begin
                    ctrl.block_start = 1'b1;
                    req_len_next     = req_len;
                    avail_next       = avail_now;
                    issued_next      = '0;
                    state_next       = S_RUN;
                    if (req_item.flush_first)
                    begin
                        r_slot_next = w_slot_reg;
                        r_wrap_next = w_wrap_reg;
                    end
                    if ((avail_now < req_len) && !starve_reg && (underrun_reg != '1))
                    begin
                        underrun_next = underrun_reg + 1'b1;
                    end
                end
            end
            S_RUN:
            begin
                if (iss_fire)
                begin
                    ctrl.iss_valid  = 1'b1;
                    ctrl.iss_filled = iss_filled;
                    ctrl.iss_last   = iss_last;
                    issued_next     = issued_reg + 1'b1;
                    if (iss_filled)
                    begin
                        rd_en = 1'b1;
                        if (r_slot_reg == AW'(CAPACITY - 1))
                        begin
                            r_slot_next = '0;
                            r_wrap_next = ~r_wrap_reg;
                        end
                        else
                        begin
                            r_slot_next = r_slot_reg + 1'b1;
                        end
                    end
                    if (iss_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            w_wrap_reg   <= 1'b0;
            r_wrap_reg   <= 1'b0;
            w_slot_reg   <= '0;
            r_slot_reg   <= '0;
            req_len_reg  <= '0;
            avail_reg    <= '0;
            issued_reg   <= '0;
            underrun_reg <= '0;
            starve_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            w_wrap_reg   <= w_wrap_next;
            r_wrap_reg   <= r_wrap_next;
            w_slot_reg   <= w_slot_next;
            r_slot_reg   <= r_slot_next;
            req_len_reg  <= req_len_next;
            avail_reg    <= avail_next;
            issued_reg   <= issued_next;
            underrun_reg <= underrun_next;
            starve_reg   <= starve_next;
        end
    end

    assign underrun_total = underrun_reg;
    assign wr_addr        = w_slot_reg;
    assign wr_data        = {req_item.in_left, req_item.in_right};
    assign rd_addr        = r_slot_reg;

    `SFFPM_ASSERT_IMPL(a_level_bound, 1'b1, level <= LW'(CAPACITY), "fill level above capacity")
    `SFFPM_ASSERT_IMPL(a_read_not_empty, iss_fire && iss_filled, level != '0, "store read while empty")
    `SFFPM_ASSERT_NEXT(a_last_to_idle, iss_fire && iss_last, state_reg == S_IDLE, "block did not end")
    `SFFPM_ASSERT_NEXT(a_underrun_grows, 1'b1, underrun_reg >= $past(underrun_reg), "underrun fell")

endmodule

>>> rtl/sffpm_out_stage.sv
`timescale 1ns / 1ps
`include "stereo_frame_fifo_with_peak_meter_defines.svh"
// ----------------------------------------------------------------------------
// Stereo frame FIFO output stage
// Takes the registered store data, applies zero fill, tracks the running
// peaks and delivered count, and buffers results in a two-entry queue.
// ----------------------------------------------------------------------------
module sffpm_out_stage
    import sffpm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  seq_ctrl_t          ctrl,
    input  logic [FRAME_W-1:0] rd_data,
    input  logic [TOTAL_W-1:0] underrun_total,
    output logic               issue_ok,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output rsp_item_t          rsp_item
);

    logic               land_valid_reg;
    logic               land_filled_reg;
    logic               land_last_reg;
    logic [PEAK_W-1:0]  peak_l_reg, peak_l_next;
    logic [PEAK_W-1:0]  peak_r_reg, peak_r_next;
    logic [COUNT_W-1:0] dlv_reg, dlv_next;
    logic               head_valid_reg, head_valid_next;
    logic               skid_valid_reg, skid_valid_next;
    rsp_item_t          head_reg, head_next;
    rsp_item_t          skid_reg, skid_next;

    logic [SAMPLE_W-1:0] left;
    logic [SAMPLE_W-1:0] right;
    logic [PEAK_W-1:0]   mag_l;
    logic [PEAK_W-1:0]   mag_r;
    rsp_item_t           land_item;
    logic                pop;
    logic [1:0]          occ;

    assign left  = land_filled_reg ? rd_data[FRAME_W-1:SAMPLE_W] : '0;
    assign right = land_filled_reg ? rd_data[SAMPLE_W-1:0] : '0;
    assign mag_l = magnitude(left);
    assign mag_r = magnitude(right);

    always_comb
    begin
        land_item.out_left       = left;
        land_item.out_right      = right;
        land_item.filled         = land_filled_reg;
        land_item.last           = land_last_reg;
        land_item.peak_left      = (mag_l > peak_l_reg) ? mag_l : peak_l_reg;
        land_item.peak_right     = (mag_r > peak_r_reg) ? mag_r : peak_r_reg;
        land_item.delivered      = dlv_reg + COUNT_W'(land_filled_reg);
        land_item.underrun_total = underrun_total;
    end

    // A new block restarts the meter even if the previous block's last frame
    // lands in the same cycle; that frame already carries its own totals.
    always_comb
    begin
        peak_l_next = peak_l_reg;
        peak_r_next = peak_r_reg;
        dlv_next    = dlv_reg;
        if (ctrl.block_start)
        begin
            peak_l_next = '0;
            peak_r_next = '0;
            dlv_next    = '0;
        end
        else if (land_valid_reg)
        begin
            peak_l_next = land_item.peak_left;
            peak_r_next = land_item.peak_right;
            dlv_next    = land_item.delivered;
        end
    end

    assign pop      = head_valid_reg && rsp_ready;
    assign occ      = 2'(head_valid_reg) + 2'(skid_valid_reg) + 2'(land_valid_reg);
    assign issue_ok = (occ < 2'd2) || ((occ == 2'd2) && pop);

    always_comb
    begin
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_next       = head_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                head_next       = skid_reg;
                skid_valid_next = land_valid_reg;
                skid_next       = land_item;
            end
            else
            begin
                head_valid_next = land_valid_reg;
                head_next       = land_item;
            end
        end
        else if (!head_valid_reg)
        begin
            head_valid_next = land_valid_reg;
            head_next       = land_item;
        end
        else if (land_valid_reg)
        begin
            skid_valid_next = 1'b1;
            skid_next       = land_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            land_valid_reg <= 1'b0;
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
            peak_l_reg     <= '0;
            peak_r_reg     <= '0;
            dlv_reg        <= '0;
        end
        else
        begin
            land_valid_reg <= ctrl.iss_valid;
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
            peak_l_reg     <= peak_l_next;
            peak_r_reg     <= peak_r_next;
            dlv_reg        <= dlv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        land_filled_reg <= ctrl.iss_filled;
        land_last_reg   <= ctrl.iss_last;
        head_reg        <= head_next;
        skid_reg        <= skid_next;
    end

    assign rsp_valid = head_valid_reg;
    assign rsp_item  = head_reg;

    `SFFPM_ASSERT_IMPL(a_skid_needs_head, skid_valid_reg, head_valid_reg, "skid without head")
    `SFFPM_ASSERT_IMPL(a_no_overfill, 1'b1, occ <= 2'd2, "output queue overfilled")

endmodule

>>> rtl/stereo_frame_fifo_with_peak_meter.sv
// A push item is stored at the edge that accepts it. A read item's frames pass
// through the landing registers and the output queue. Throughput: one push
// item per cycle while no read block runs; a read block issues one frame per
// cycle through the single store read port while the output stage has room,
// and the next item is taken the cycle after its last frame issues. Reset
// clears pointers, underrun counter and register, not the frame store.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo frame FIFO with peak meter
// Queue of stereo Q1.23 frames with block reads, zero fill on underflow,
// per-block absolute peak metering and a saturating underrun counter.
// ----------------------------------------------------------------------------
module stereo_frame_fifo_with_peak_meter
    import sffpm_pkg::*;
#(
    parameter int CAPACITY  = 1024,
    parameter int MAX_BLOCK = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_item_t req_item,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_item_t rsp_item,
    input  logic      cfg_we,
    input  logic      cfg_wdata
);

    // The store is addressed by slot; each pointer is a slot plus a wrap bit,
    // so the capacity need not be a power of two.
    localparam int AW = $clog2(CAPACITY);

    seq_ctrl_t          ctrl;
    logic               issue_ok;
    logic [TOTAL_W-1:0] underrun_total;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [FRAME_W-1:0] wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [FRAME_W-1:0] rd_data;

    // The sequencer accepts items only while no read block is issuing. A push
    // writes the store and is dropped instead when the queue is full. A
    // read block optionally flushes, fixes its fill count and underrun status
    // at acceptance, then steps through its frames one per cycle whenever the
    // output stage has room.
    sffpm_seq #(
        .CAPACITY  (CAPACITY),
        .MAX_BLOCK (MAX_BLOCK),
        .AW        (AW)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req_item       (req_item),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .issue_ok       (issue_ok),
        .ctrl           (ctrl),
        .underrun_total (underrun_total),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_data        (wr_data),
        .rd_en          (rd_en),
        .rd_addr        (rd_addr)
    );

    // Frame store with a registered read port.
    sffpm_frame_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // The output stage meters each frame as it arrives from the store and
    // keeps a two-entry queue, so a stalled consumer never loses an item and
    // an unstalled one sees one item per cycle while a read block issues.
    sffpm_out_stage u_out (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .rd_data        (rd_data),
        .underrun_total (underrun_total),
        .issue_ok       (issue_ok),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .rsp_item       (rsp_item)
    );

endmodule

>>> tb/tb_stereo_frame_fifo_with_peak_meter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo frame FIFO with peak meter testbench
// Drives push and block-read items through the valid/ready request channel.
// A shadow copy of the frame queue predicts every returned frame, with its
// running peaks, delivered count and underrun total. Each frame from the
// response channel is checked field by field in order. Random stalls on both
// channels come within phases; the starvation register changes between them.
// ----------------------------------------------------------------------------
module tb_stereo_frame_fifo_with_peak_meter;

    import sffpm_pkg::*;

    localparam int QUEUE_DEPTH   = 1024;
    localparam int BLOCK_MAX     = 64;
    localparam int PTR_W         = $clog2(2 * QUEUE_DEPTH);
    localparam int SLOT_W        = $clog2(QUEUE_DEPTH);
    // Quiet time after the last owed frame, to let anything in flight drain.
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 32;

    // One row of the directed plan. A row with more than one copy is a burst
    // of pushes with random samples; a typed row carries its single frame.
    typedef struct {
        req_item_t   item;
        int unsigned copies;
        bit          typed;
        rsp_item_t   want;
    } plan_row_t;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    req_item_t req_item  = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    rsp_item_t rsp_item;
    logic      cfg_we    = 1'b0;
    logic      cfg_wdata = 1'b0;

    // Shadow copy of the queue, its pointers and the underrun counter.
    logic [SAMPLE_W-1:0] shadow_left  [QUEUE_DEPTH];
    logic [SAMPLE_W-1:0] shadow_right [QUEUE_DEPTH];
    bit   [PTR_W-1:0]    shadow_wr;
    bit   [PTR_W-1:0]    shadow_rd;
    bit   [TOTAL_W-1:0]  shadow_underruns;
    bit                  starve_ok;

    // Frames the block still owes us, oldest first.
    rsp_item_t   frames_due [$];
    plan_row_t   plan [$];

    bit          idle_on;
    int unsigned mismatches;
    int unsigned items_sent;
    int unsigned frames_checked;
    int unsigned short_blocks;
    int unsigned dropped_pushes;

    stereo_frame_fifo_with_peak_meter #(
        .CAPACITY  (QUEUE_DEPTH),
        .MAX_BLOCK (BLOCK_MAX)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_item  (rsp_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Absolute value of a Q1.23 sample. The most negative code has no positive
    // twin, so it clips to full scale.
    function automatic bit [PEAK_W-1:0] abs_q23(input bit [SAMPLE_W-1:0] s);
        bit [SAMPLE_W-1:0] neg;
        neg = ~s + 1'b1;
        if (!s[SAMPLE_W-1])
        begin
            return s[PEAK_W-1:0];
        end
        if (neg[SAMPLE_W-1])
        begin
            return '1;
        end
        return neg[PEAK_W-1:0];
    endfunction

    // Apply one accepted item to the shadow queue and queue up the frames it
    // should produce.
    function automatic void predict_item(input req_item_t it);
        bit [PTR_W-1:0]  level;
        int unsigned     want_n;
        int unsigned     avail;
        bit [PEAK_W-1:0] pk_l;
        bit [PEAK_W-1:0] pk_r;
        bit [PEAK_W-1:0] m;
        bit [COUNT_W-1:0] got;
        rsp_item_t       f;
        level = shadow_wr - shadow_rd;
        if (it.opcode == OP_PUSH)
        begin
            // A full queue drops the frame and leaves everything untouched.
            if (32'(level) < QUEUE_DEPTH)
            begin
                shadow_left[shadow_wr[SLOT_W-1:0]]  = it.in_left;
                shadow_right[shadow_wr[SLOT_W-1:0]] = it.in_right;
                shadow_wr = shadow_wr + 1'b1;
            end
            else
            begin
                dropped_pushes++;
            end
            return;
        end
        want_n = 32'(it.block_frames);
        if (want_n == 0)
        begin
            want_n = 1;
        end
        if (want_n > BLOCK_MAX)
        begin
            want_n = BLOCK_MAX;
        end
        if (it.flush_first)
        begin
            shadow_rd = shadow_wr;
        end
        level = shadow_wr - shadow_rd;
        avail = (32'(level) > want_n) ? want_n : 32'(level);
        if (avail < want_n)
        begin
            short_blocks++;
            if (!starve_ok && shadow_underruns != '1)
            begin
                shadow_underruns = shadow_underruns + 1'b1;
            end
        end
        pk_l = '0;
        pk_r = '0;
        got  = '0;
        for (int unsigned i = 0; i < want_n; i++)
        begin
            f = '0;
            if (i < avail)
            begin
                f.out_left  = shadow_left[shadow_rd[SLOT_W-1:0]];
                f.out_right = shadow_right[shadow_rd[SLOT_W-1:0]];
                f.filled    = 1'b1;
                shadow_rd   = shadow_rd + 1'b1;
                m = abs_q23(f.out_left);
                if (m > pk_l)
                begin
                    pk_l = m;
                end
                m = abs_q23(f.out_right);
                if (m > pk_r)
                begin
                    pk_r = m;
                end
                got = got + 1'b1;
            end
            f.last           = (i + 1 == want_n);
            f.peak_left      = pk_l;
            f.peak_right     = pk_r;
            f.delivered      = got;
            f.underrun_total = shadow_underruns;
            frames_due.push_back(f);
        end
    endfunction

    // Compare one returned frame with its expectation; returns the number of
    // fields that differ.
    function automatic int unsigned check_frame(input rsp_item_t got, input rsp_item_t want);
        int unsigned bad;
        bad = 0;
        if (got.out_left !== want.out_left)
        begin
            $error("out_left: expected %0d, actual %0d", want.out_left, got.out_left);
            bad++;
        end
        if (got.out_right !== want.out_right)
        begin
            $error("out_right: expected %0d, actual %0d", want.out_right, got.out_right);
            bad++;
        end
        if (got.filled !== want.filled)
        begin
            $error("filled: expected %0d, actual %0d", want.filled, got.filled);
            bad++;
        end
        if (got.last !== want.last)
        begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            bad++;
        end
        if (got.peak_left !== want.peak_left)
        begin
            $error("peak_left: expected %0h, actual %0h", want.peak_left, got.peak_left);
            bad++;
        end
        if (got.peak_right !== want.peak_right)
        begin
            $error("peak_right: expected %0h, actual %0h", want.peak_right, got.peak_right);
            bad++;
        end
        if (got.delivered !== want.delivered)
        begin
            $error("delivered: expected %0d, actual %0d", want.delivered, got.delivered);
            bad++;
        end
        if (got.underrun_total !== want.underrun_total)
        begin
            $error("underrun_total: expected %0d, actual %0d",
                   want.underrun_total, got.underrun_total);
            bad++;
        end
        return bad;
    endfunction

    // Samples lean on the corners of the Q1.23 range now and then.
    function automatic logic [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 11))
            0:       return 24'h800000;
            1:       return 24'h7FFFFF;
            2:       return 24'hFFFFFF;
            3:       return 24'h800001;
            4:       return 24'h000000;
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    // Mostly lengths in the legal range, with the odd zero or oversize request.
    function automatic logic [COUNT_W-1:0] random_block_len();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return COUNT_W'($urandom_range(BLOCK_MAX + 1, 127));
            2, 3, 4: return COUNT_W'($urandom_range(9, BLOCK_MAX));
            default: return COUNT_W'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic void plan_push(input int l, input int r, input int unsigned copies);
        plan_row_t row;
        row.item          = '0;
        row.item.opcode   = OP_PUSH;
        row.item.in_left  = l[SAMPLE_W-1:0];
        row.item.in_right = r[SAMPLE_W-1:0];
        row.copies        = copies;
        row.typed         = 1'b0;
        row.want          = '0;
        plan.push_back(row);
    endfunction

    function automatic void plan_read(input int n, input bit fl, input bit typed,
                                      input rsp_item_t want);
        plan_row_t row;
        row.item              = '0;
        row.item.opcode       = OP_READ;
        row.item.block_frames = n[COUNT_W-1:0];
        row.item.flush_first  = fl;
        row.copies            = 1;
        row.typed             = typed;
        row.want              = want;
        plan.push_back(row);
    endfunction

    // The only frame of a one-frame block, so it is always the last one.
    function automatic rsp_item_t single_frame(input int l, input int r, input bit f,
                                               input int pl, input int pr,
                                               input int d, input int u);
        rsp_item_t x;
        x.out_left       = l[SAMPLE_W-1:0];
        x.out_right      = r[SAMPLE_W-1:0];
        x.filled         = f;
        x.last           = 1'b1;
        x.peak_left      = pl[PEAK_W-1:0];
        x.peak_right     = pr[PEAK_W-1:0];
        x.delivered      = d[COUNT_W-1:0];
        x.underrun_total = u;
        return x;
    endfunction

    // Hold the item on the request channel until it is taken, with an optional
    // idle burst first. Valid is only lowered when a gap is actually inserted,
    // so back-to-back items never see a low and a high in the same step.
    task automatic offer_item(input req_item_t it);
        int unsigned gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 12);
        end
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= it;
        do
        begin
            @(posedge clk);
        end
        while (!req_ready);
        predict_item(it);
        items_sent++;
    endtask

    // Stop sending and wait until every owed frame has come back, then give
    // the pipeline extra time to go quiet.
    task automatic settle();
        req_valid <= 1'b0;
        while (frames_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_starvation(input bit v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        starve_ok = v;
    endtask

    // Well-formed traffic: a run of pushes followed by a read of the same
    // length, so the reads mostly drain exactly what was written. One read in
    // four asks for a random length instead. Any read may flush or come up short.
    task automatic run_random_phase(input int unsigned target);
        int unsigned sent;
        int unsigned k;
        req_item_t   it;
        sent = 0;
        while (sent < target)
        begin
            k = $urandom_range(1, 8);
            for (int unsigned j = 0; j < k; j++)
            begin
                it          = '0;
                it.opcode   = OP_PUSH;
                it.in_left  = random_sample();
                it.in_right = random_sample();
                offer_item(it);
                sent++;
            end
            it              = '0;
            it.opcode       = OP_READ;
            it.in_left      = SAMPLE_W'($urandom());
            it.in_right     = SAMPLE_W'($urandom());
            it.block_frames = ($urandom_range(0, 3) != 0) ? k[COUNT_W-1:0]
                                                          : random_block_len();
            it.flush_first  = ($urandom_range(0, 11) == 0);
            offer_item(it);
            sent++;
        end
    endtask

    // Response side: check every taken frame against the oldest expectation,
    // and stall in random bursts while idling is on.
    initial
    begin : frame_sink
        int unsigned stall_left;
        logic        nxt_ready;
        rsp_item_t   want;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && rsp_ready)
            begin
                if (frames_due.size() == 0)
                begin
                    $error("rsp_item: expected no frame, actual %0h", rsp_item);
                    mismatches++;
                end
                else
                begin
                    want = frames_due.pop_front();
                    mismatches += check_frame(rsp_item, want);
                    frames_checked++;
                end
            end
            if (!rst_n)
            begin
                nxt_ready = 1'b0;
            end
            else if (!idle_on)
            begin
                nxt_ready = 1'b1;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                nxt_ready = 1'b0;
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 12) - 1;
                nxt_ready  = 1'b0;
            end
            else
            begin
                nxt_ready = 1'b1;
            end
            rsp_ready <= nxt_ready;
        end
    end

    // Main sequence: reset, the directed plan, then three random phases with
    // the starvation register toggled in between. The last phase runs without
    // any idling on either side.
    initial
    begin : stimulus
        req_item_t it;
        idle_on          = 1'b1;
        mismatches       = 0;
        items_sent       = 0;
        frames_checked   = 0;
        short_blocks     = 0;
        dropped_pushes   = 0;
        shadow_wr        = '0;
        shadow_rd        = '0;
        shadow_underruns = '0;
        starve_ok        = 1'b0;

        // Reads on an empty queue: a one-frame block and a zero-length block,
        // which the block treats as one frame. Both come up short.
        plan_read(1, 1'b0, 1'b1, single_frame(0, 0, 1'b0, 0, 0, 0, 1));
        plan_read(0, 1'b0, 1'b1, single_frame(0, 0, 1'b0, 0, 0, 0, 2));
        // Full-scale samples; the most negative one clips to full-scale peak.
        plan_push(-8388608, 8388607, 1);
        plan_read(1, 1'b0, 1'b1,
                  single_frame(-8388608, 8388607, 1'b1, 'h7FFFFF, 'h7FFFFF, 1, 2));
        plan_push(8388607, -8388608, 1);
        plan_push(0, -1, 1);
        plan_push(-8388607, 1, 1);
        plan_push(1, 0, 1);
        plan_read(4, 1'b0, 1'b0, '0);
        // An oversize request is cut to the largest block and zero-filled.
        plan_read(127, 1'b0, 1'b0, '0);
        // Flush drops the pending frames before the block is read.
        plan_push(5, 5, 1);
        plan_push(6, -6, 1);
        plan_read(2, 1'b1, 1'b0, '0);
        // A short burst of random frames read by a full-size block, which
        // delivers the burst and then zero-fills the rest.
        plan_push(0, 0, 8);
        plan_read(BLOCK_MAX, 1'b0, 1'b0, '0);
        plan_push(123456, -654321, 1);
        plan_read(BLOCK_MAX, 1'b1, 1'b0, '0);
        plan_push(-1, -1, 1);
        plan_read(1, 1'b0, 1'b1, single_frame(-1, -1, 1'b1, 1, 1, 1, 6));
        plan_read(1, 1'b1, 1'b1, single_frame(0, 0, 1'b0, 0, 0, 0, 7));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_starvation(1'b0);

        foreach (plan[i])
        begin
            if (plan[i].copies > 1)
            begin
                for (int unsigned c = 0; c < plan[i].copies; c++)
                begin
                    it          = plan[i].item;
                    it.in_left  = random_sample();
                    it.in_right = random_sample();
                    offer_item(it);
                end
            end
            else
            begin
                offer_item(plan[i].item);
                // Typed rows replace the predicted frame with the one written
                // out by hand above.
                if (plan[i].typed)
                begin
                    frames_due[frames_due.size() - 1] = plan[i].want;
                end
            end
        end

        settle();
        write_starvation(1'b1);
        run_random_phase(PHASE_ITEMS);
        settle();
        write_starvation(1'b0);
        run_random_phase(PHASE_ITEMS);
        settle();
        write_starvation(1'b1);
        idle_on = 1'b0;
        run_random_phase(PHASE_ITEMS);
        settle();

        $display("Sent %0d items and checked %0d frames across both starvation settings.",
                 items_sent, frames_checked);
        $display("Saw %0d short blocks and %0d pushes dropped on a full queue.",
                 short_blocks, dropped_pushes);
        if (mismatches == 0)
        begin
            $display("stereo_frame_fifo_with_peak_meter: match");
        end
        else
        begin
            $display("stereo_frame_fifo_with_peak_meter: mismatch");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("stereo_frame_fifo_with_peak_meter: mismatch");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/sffpm_pkg.sv
rtl/sffpm_frame_ram.sv
rtl/sffpm_seq.sv
rtl/sffpm_out_stage.sv
rtl/stereo_frame_fifo_with_peak_meter.sv
tb/tb_stereo_frame_fifo_with_peak_meter.sv
